// ===== hw/rtl/scp_pkg.sv =====
// Shared types, constants and helpers of the polygon scan converter.
// No dependencies; every other file of the block imports this package.
package scp_pkg;

  localparam int IN_W = 32;
  localparam int OUT_W = 40;
  localparam int SPAN_W = 12;
  localparam int SPAN_LIMIT = 16;
  localparam int SPAN_CNT_W = 5;
  localparam int DIV_W = 64;
  localparam int DVS_W = 20;

  localparam logic OP_LOAD = 1'b0;

  localparam logic [1:0] EC_NONE = 2'd0;
  localparam logic [1:0] EC_REMOVE = 2'd1;
  localparam logic [1:0] EC_ADD = 2'd2;

  localparam logic [1:0] RD_PREV = 2'd0;
  localparam logic [1:0] RD_NEXT = 2'd1;
  localparam logic [1:0] RD_CUR = 2'd2;

  localparam logic [1:0] EM_NONE = 2'd0;
  localparam logic [1:0] EM_EMPTY = 2'd1;
  localparam logic [1:0] EM_FINAL = 2'd2;

  typedef struct packed {
    logic       take;
    logic       load;
    logic       vsort;
    logic       sort_odd;
    logic       prep;
    logic       pop;
    logic [1:0] rd_kind;
    logic       lat_prev;
    logic       lat_next;
    logic       lat_cur;
    logic       remove;
    logic       sel_next;
    logic       add_setup;
    logic       div_start;
    logic       div_x;
    logic       slope_store;
    logic       mul;
    logic       edge_write;
    logic       esort;
    logic       span_init;
    logic       rot;
    logic [1:0] emit;
    logic       row_update;
  } cmd_t;

  typedef struct packed {
    logic       op;
    logic       fin;
    logic       prepared;
    logic       finished;
    logic       head_ok;
    logic [1:0] prev_code;
    logic [1:0] next_code;
    logic       add_ok;
    logic       div_done;
    logic       out_free;
    logic       span_hit;
    logic       pend_valid;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end
    if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== hw/rtl/scp_div.sv =====
// Bit-serial signed floor divider by a positive divisor, one quotient bit a cycle.
// Depends on scp_pkg.
module scp_div import scp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0]        divisor,
  output logic                    done,
  output logic signed [DIV_W-1:0] quotient
);

  localparam int CNTW = $clog2(DIV_W);

  logic             busy;
  logic             fix;
  logic             neg;
  logic [CNTW-1:0]  cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DIV_W-1:0] quo;
  logic [DVS_W:0]   sh;
  logic [DVS_W:0]   diff;

  always_comb begin
    sh = {rem, quo[DIV_W-1]};
    diff = sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        neg <= dividend[DIV_W-1];
        quo <= dividend[DIV_W-1] ? -dividend : dividend;
        rem <= '0;
        dvs <= divisor;
        cnt <= CNTW'(DIV_W - 1);
      end else if (busy) begin
        rem <= diff[DVS_W] ? sh[DVS_W-1:0] : diff[DVS_W-1:0];
        quo <= {quo[DIV_W-2:0], ~diff[DVS_W]};
        if (cnt == '0) begin
          busy <= 1'b0;
          fix <= 1'b1;
        end else begin
          cnt <= cnt - CNTW'(1);
        end
      end else if (fix) begin
        quotient <= neg ? (-quo - DIV_W'(rem != '0)) : quo;
        done <= 1'b1;
        fix <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/scp_datapath.sv =====
// Datapath of the scan converter: vertex memory, sorted vertex lanes, active edge
// lanes, span pairing and the output register. Depends on scp_pkg and scp_div.
module scp_datapath import scp_pkg::*; #(
  parameter int MAX_VERTICES = 32,
  parameter int COORD_FRAC_BITS = 4,
  parameter int EDGE_FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic             s_tuser,
  input  logic             s_tlast,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tlast
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int ED = MAX_VERTICES + (MAX_VERTICES % 2);
  localparam int EIW = $clog2(ED);
  localparam int RW = 17 - COORD_FRAC_BITS;
  localparam int BW = 20;
  localparam int SH = EDGE_FRAC_BITS - COORD_FRAC_BITS;
  localparam int PW = 17 + BW;
  localparam logic signed [BW-1:0] ONE_B = 1;
  localparam logic signed [17:0] HALF_Y = 18'(2 ** COORD_FRAC_BITS);
  localparam logic signed [17:0] RND_Y = 18'(2 ** (COORD_FRAC_BITS + 1) - 1);
  localparam logic signed [33:0] HALF_E = 34'(2 ** (EDGE_FRAC_BITS - 1));
  localparam logic signed [33:0] RND_E = 34'(2 ** EDGE_FRAC_BITS - 1);
  localparam logic signed [33:0] LIM_LO = -34'sd2048;
  localparam logic signed [33:0] LIM_HI = 34'sd2047;

  logic                     in_op;
  logic                     in_fin;
  logic signed [15:0]       in_x;
  logic signed [15:0]       in_y;
  logic signed [15:0]       vxm [MAX_VERTICES];
  logic signed [15:0]       vym [MAX_VERTICES];
  logic signed [15:0]       rd_x;
  logic signed [15:0]       rd_y;
  logic [IW-1:0]            rd_addr;
  logic signed [15:0]       vl_y [MAX_VERTICES];
  logic [IW-1:0]            vl_i [MAX_VERTICES];
  logic signed [15:0]       vl_y_next [MAX_VERTICES];
  logic [IW-1:0]            vl_i_next [MAX_VERTICES];
  logic [CW-1:0]            vcount;
  logic [CW-1:0]            pos;
  logic [CW-1:0]            active;
  logic signed [15:0]       ymin;
  logic signed [15:0]       ymax;
  logic signed [RW-1:0]     cur_row;
  logic signed [RW-1:0]     bot_row;
  logic                     prepared;
  logic                     finished;
  logic                     overflow;
  logic [IW-1:0]            cur_i;
  logic [IW-1:0]            prev_i;
  logic [IW-1:0]            next_i;
  logic signed [15:0]       pv_x;
  logic signed [15:0]       pv_y;
  logic signed [15:0]       nv_x;
  logic signed [15:0]       nv_y;
  logic signed [15:0]       cv_x;
  logic signed [15:0]       cv_y;
  logic signed [BW-1:0]     row2;
  logic signed [BW-1:0]     hi;
  logic signed [BW-1:0]     lo;
  logic signed [BW-1:0]     py2;
  logic signed [BW-1:0]     ny2;
  logic signed [15:0]       a_x;
  logic signed [15:0]       a_y;
  logic signed [15:0]       b_x;
  logic signed [15:0]       b_y;
  logic signed [15:0]       p_x;
  logic signed [15:0]       p_y;
  logic signed [15:0]       q_x;
  logic signed [15:0]       q_y;
  logic [IW-1:0]            sel_id;
  logic signed [15:0]       ad_px;
  logic signed [16:0]       ad_dx;
  logic signed [16:0]       ad_dy;
  logic signed [BW-1:0]     ad_t2;
  logic [IW-1:0]            ad_id;
  logic                     ad_ok;
  logic signed [PW-1:0]     prod;
  logic signed [31:0]       slope_r;
  logic signed [DIV_W-1:0]  div_a;
  logic [DVS_W-1:0]         div_d;
  logic                     div_done;
  logic signed [DIV_W-1:0]  div_q;
  logic signed [31:0]       ex [ED];
  logic signed [31:0]       es [ED];
  logic [IW-1:0]            eid [ED];
  logic signed [31:0]       ex_next [ED];
  logic signed [31:0]       es_next [ED];
  logic [IW-1:0]            eid_next [ED];
  logic                     rm_found;
  logic [EIW-1:0]           rm_j;
  logic [EIW-1:0]           pair;
  logic [SPAN_CNT_W-1:0]    spans;
  logic                     pend_valid;
  logic [SPAN_W-1:0]        pend_l;
  logic [SPAN_W-1:0]        pend_r;
  logic signed [33:0]       xl;
  logic signed [33:0]       xr;
  logic                     pair_ok;
  logic                     hit;
  logic [SPAN_W-1:0]        cl;
  logic [SPAN_W-1:0]        cr;
  logic                     adv_done;
  logic                     out_free;
  logic [CW-1:0]            base;
  logic signed [17:0]       vt_top;
  logic signed [17:0]       vt_bot;

  scp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    row2 = BW'(cur_row) <<< 1;
    hi = (row2 + ONE_B) <<< COORD_FRAC_BITS;
    lo = (row2 - ONE_B) <<< COORD_FRAC_BITS;
    py2 = BW'(pv_y) <<< 1;
    ny2 = BW'(nv_y) <<< 1;
    prev_i = (cur_i == '0) ? IW'(vcount - CW'(1)) : cur_i - IW'(1);
    next_i = ((CW'(cur_i) + CW'(1)) < vcount) ? cur_i + IW'(1) : '0;
    case (cmd.rd_kind)
      RD_PREV: rd_addr = prev_i;
      RD_NEXT: rd_addr = next_i;
      default: rd_addr = cur_i;
    endcase
    a_x = cmd.sel_next ? cv_x : pv_x;
    a_y = cmd.sel_next ? cv_y : pv_y;
    b_x = cmd.sel_next ? nv_x : cv_x;
    b_y = cmd.sel_next ? nv_y : cv_y;
    sel_id = cmd.sel_next ? cur_i : prev_i;
    if (a_y >= b_y) begin
      p_x = b_x;
      p_y = b_y;
      q_x = a_x;
      q_y = a_y;
    end else begin
      p_x = a_x;
      p_y = a_y;
      q_x = b_x;
      q_y = b_y;
    end
    if (cmd.div_x) begin
      div_a = DIV_W'(prod) <<< SH;
      div_d = DVS_W'(ad_dy) << 1;
    end else begin
      div_a = DIV_W'(ad_dx) <<< EDGE_FRAC_BITS;
      div_d = DVS_W'(ad_dy);
    end
    base = prepared ? '0 : vcount;
    vt_top = (18'(ymin) <<< 1) - HALF_Y;
    vt_bot = (18'(ymax) <<< 1) - HALF_Y;
  end

  always_comb begin
    rm_found = 1'b0;
    rm_j = '0;
    for (int k = ED - 1; k >= 0; k--) begin
      if ((CW'(k) < active) && (eid[k] == sel_id)) begin
        rm_found = 1'b1;
        rm_j = EIW'(k);
      end
    end
  end

  always_comb begin
    xl = ((34'(ex[0]) - HALF_E) + RND_E) >>> EDGE_FRAC_BITS;
    xr = (34'(ex[1]) - HALF_E) >>> EDGE_FRAC_BITS;
    pair_ok = (CW'({pair, 1'b1}) < active) && ((CW + 1)'({pair, 1'b1}) < (CW + 1)'(active));
    hit = pair_ok && (xl <= xr) && (xr >= LIM_LO) && (xl <= LIM_HI)
          && (spans < SPAN_CNT_W'(SPAN_LIMIT));
    cl = (xl < LIM_LO) ? LIM_LO[SPAN_W-1:0] : xl[SPAN_W-1:0];
    cr = (xr > LIM_HI) ? LIM_HI[SPAN_W-1:0] : xr[SPAN_W-1:0];
    adv_done = cur_row >= bot_row;
    out_free = !m_tvalid || m_tready;
  end

  always_comb begin
    ex_next = ex;
    es_next = es;
    eid_next = eid;
    if (cmd.remove && rm_found) begin
      for (int k = 0; k < ED - 1; k++) begin
        if (EIW'(k) >= rm_j) begin
          ex_next[k] = ex[k+1];
          es_next[k] = es[k+1];
          eid_next[k] = eid[k+1];
        end
      end
    end else if (cmd.edge_write) begin
      ex_next[active[EIW-1:0]] = sat32((66'(ad_px) <<< SH) + 66'(div_q));
      es_next[active[EIW-1:0]] = slope_r;
      eid_next[active[EIW-1:0]] = ad_id;
    end else if (cmd.esort) begin
      for (int k = 0; k < ED - 1; k++) begin
        if (((k % 2) == int'(cmd.sort_odd)) && (CW'(k + 1) < active) && (ex[k] > ex[k+1])) begin
          ex_next[k] = ex[k+1];
          es_next[k] = es[k+1];
          eid_next[k] = eid[k+1];
          ex_next[k+1] = ex[k];
          es_next[k+1] = es[k];
          eid_next[k+1] = eid[k];
        end
      end
    end else if (cmd.rot) begin
      for (int k = 0; k < ED - 2; k++) begin
        ex_next[k] = ex[k+2];
        es_next[k] = es[k+2];
        eid_next[k] = eid[k+2];
      end
      ex_next[ED-2] = sat32(66'(ex[0]) + 66'(es[0]));
      ex_next[ED-1] = sat32(66'(ex[1]) + 66'(es[1]));
      es_next[ED-2] = es[0];
      es_next[ED-1] = es[1];
      eid_next[ED-2] = eid[0];
      eid_next[ED-1] = eid[1];
    end
  end

  always_comb begin
    vl_y_next = vl_y;
    vl_i_next = vl_i;
    if (cmd.load && (base < CW'(MAX_VERTICES))) begin
      vl_y_next[base[IW-1:0]] = in_y;
      vl_i_next[base[IW-1:0]] = base[IW-1:0];
    end else if (cmd.vsort) begin
      for (int k = 0; k < MAX_VERTICES - 1; k++) begin
        if (((k % 2) == int'(cmd.sort_odd)) && (CW'(k + 1) < vcount)
            && (vl_y[k] > vl_y[k+1])) begin
          vl_y_next[k] = vl_y[k+1];
          vl_i_next[k] = vl_i[k+1];
          vl_y_next[k+1] = vl_y[k];
          vl_i_next[k+1] = vl_i[k];
        end
      end
    end else if (cmd.pop) begin
      for (int k = 0; k < MAX_VERTICES - 1; k++) begin
        vl_y_next[k] = vl_y[k+1];
        vl_i_next[k] = vl_i[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    ex <= ex_next;
    es <= es_next;
    eid <= eid_next;
    vl_y <= vl_y_next;
    vl_i <= vl_i_next;
    rd_x <= vxm[rd_addr];
    rd_y <= vym[rd_addr];
    if (cmd.load && (base < CW'(MAX_VERTICES))) begin
      vxm[base[IW-1:0]] <= in_x;
      vym[base[IW-1:0]] <= in_y;
    end
    if (cmd.take) begin
      in_x <= s_tdata[15:0];
      in_y <= s_tdata[31:16];
      in_op <= s_tuser;
      in_fin <= s_tlast;
    end
    if (cmd.pop) begin
      cur_i <= vl_i[0];
    end
    if (cmd.lat_prev) begin
      pv_x <= rd_x;
      pv_y <= rd_y;
    end
    if (cmd.lat_next) begin
      nv_x <= rd_x;
      nv_y <= rd_y;
    end
    if (cmd.lat_cur) begin
      cv_x <= rd_x;
      cv_y <= rd_y;
    end
    if (cmd.add_setup) begin
      ad_px <= p_x;
      ad_dx <= 17'(q_x) - 17'(p_x);
      ad_dy <= 17'(q_y) - 17'(p_y);
      ad_t2 <= hi - (BW'(p_y) <<< 1);
      ad_id <= sel_id;
      ad_ok <= (q_y > p_y) && (active < CW'(MAX_VERTICES));
    end
    if (cmd.mul) begin
      prod <= PW'(ad_dx) * PW'(ad_t2);
    end
    if (cmd.slope_store) begin
      slope_r <= sat32(66'(div_q));
    end
    if (cmd.rot && hit) begin
      pend_l <= cl;
      pend_r <= cr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= '0;
      pos <= '0;
      active <= '0;
      cur_row <= '0;
      bot_row <= '0;
      prepared <= 1'b0;
      finished <= 1'b0;
      overflow <= 1'b0;
      pend_valid <= 1'b0;
      spans <= '0;
      pair <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready && (cmd.emit == EM_NONE) && !(cmd.rot && hit && pend_valid)) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.load) begin
        if (prepared) begin
          active <= '0;
          pos <= '0;
          prepared <= 1'b0;
          finished <= 1'b0;
          overflow <= 1'b0;
          cur_row <= '0;
          bot_row <= '0;
        end
        if (base < CW'(MAX_VERTICES)) begin
          vcount <= base + CW'(1);
          if ((base == '0) || (in_y < ymin)) begin
            ymin <= in_y;
          end
          if ((base == '0) || (in_y > ymax)) begin
            ymax <= in_y;
          end
        end else begin
          overflow <= 1'b1;
        end
      end
      if (cmd.prep) begin
        prepared <= 1'b1;
        pos <= '0;
        active <= '0;
        if (vcount < CW'(3)) begin
          finished <= 1'b1;
          cur_row <= '0;
          bot_row <= '0;
        end else begin
          cur_row <= RW'((vt_top + RND_Y) >>> (COORD_FRAC_BITS + 1));
          bot_row <= RW'(vt_bot >>> (COORD_FRAC_BITS + 1));
          finished <= RW'((vt_top + RND_Y) >>> (COORD_FRAC_BITS + 1))
                      > RW'(vt_bot >>> (COORD_FRAC_BITS + 1));
        end
      end
      if (cmd.pop) begin
        pos <= pos + CW'(1);
      end
      if (cmd.remove && rm_found) begin
        active <= active - CW'(1);
      end
      if (cmd.edge_write) begin
        active <= active + CW'(1);
      end
      if (cmd.span_init) begin
        pend_valid <= 1'b0;
        spans <= '0;
        pair <= '0;
      end
      if (cmd.rot) begin
        pair <= pair + EIW'(1);
        if (hit) begin
          pend_valid <= 1'b1;
          spans <= spans + SPAN_CNT_W'(1);
          if (pend_valid) begin
            m_tvalid <= 1'b1;
            m_tlast <= 1'b0;
            m_tdata <= {1'b0, overflow, adv_done, 1'b1, pend_r, pend_l, SPAN_W'(cur_row)};
          end
        end
      end
      if (cmd.emit == EM_EMPTY) begin
        m_tvalid <= 1'b1;
        m_tlast <= 1'b1;
        m_tdata <= {1'b0, overflow, prepared && finished, 1'b0, SPAN_W'(0), SPAN_W'(0),
                    SPAN_W'(cur_row)};
      end else if (cmd.emit == EM_FINAL) begin
        m_tvalid <= 1'b1;
        m_tlast <= 1'b1;
        pend_valid <= 1'b0;
        if (pend_valid) begin
          m_tdata <= {1'b0, overflow, adv_done, 1'b1, pend_r, pend_l, SPAN_W'(cur_row)};
        end else begin
          m_tdata <= {1'b0, overflow, adv_done, 1'b0, SPAN_W'(0), SPAN_W'(0),
                      SPAN_W'(cur_row)};
        end
      end
      if (cmd.row_update) begin
        if (adv_done) begin
          finished <= 1'b1;
        end else begin
          cur_row <= cur_row + RW'(1);
        end
      end
    end
  end

  always_comb begin
    sts.op = in_op;
    sts.fin = in_fin;
    sts.prepared = prepared;
    sts.finished = finished;
    sts.head_ok = (pos < vcount) && ((BW'(vl_y[0]) <<< 1) <= hi);
    sts.prev_code = (py2 <= lo) ? EC_REMOVE : ((py2 > hi) ? EC_ADD : EC_NONE);
    sts.next_code = (ny2 <= lo) ? EC_REMOVE : ((ny2 > hi) ? EC_ADD : EC_NONE);
    sts.add_ok = ad_ok;
    sts.div_done = div_done;
    sts.out_free = out_free;
    sts.span_hit = hit;
    sts.pend_valid = pend_valid;
  end

endmodule

// ===== hw/rtl/scp_ctrl.sv =====
// Controller state machine of the scan converter: sequences loads, vertex sort,
// edge insertion and removal, edge sort and span output. Depends on scp_pkg.
module scp_ctrl import scp_pkg::*; #(
  parameter int MAX_VERTICES = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int ED = MAX_VERTICES + (MAX_VERTICES % 2);
  localparam int SCW = $clog2(ED + 1);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DISP = 5'd1;
  localparam logic [4:0] S_VSORT = 5'd2;
  localparam logic [4:0] S_PREP = 5'd3;
  localparam logic [4:0] S_EMIT = 5'd4;
  localparam logic [4:0] S_UPD = 5'd5;
  localparam logic [4:0] S_RDP = 5'd6;
  localparam logic [4:0] S_RDN = 5'd7;
  localparam logic [4:0] S_RDC = 5'd8;
  localparam logic [4:0] S_LATC = 5'd9;
  localparam logic [4:0] S_DECP = 5'd10;
  localparam logic [4:0] S_DECN = 5'd11;
  localparam logic [4:0] S_ADDCHK = 5'd12;
  localparam logic [4:0] S_SDIV = 5'd13;
  localparam logic [4:0] S_XSTART = 5'd14;
  localparam logic [4:0] S_XDIV = 5'd15;
  localparam logic [4:0] S_ESORT = 5'd16;
  localparam logic [4:0] S_ROT = 5'd17;
  localparam logic [4:0] S_FIN = 5'd18;

  logic [4:0]     state;
  logic [4:0]     state_next;
  logic [SCW-1:0] cnt;
  logic [SCW-1:0] cnt_next;
  logic           add_next;
  logic           add_next_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.rd_kind = RD_CUR;
    state_next = state;
    cnt_next = cnt;
    add_next_next = add_next;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.op == OP_LOAD) begin
          cmd.load = 1'b1;
          cnt_next = '0;
          state_next = sts.fin ? S_VSORT : S_EMIT;
        end else if (!sts.prepared || sts.finished) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_UPD;
        end
      end
      S_VSORT: begin
        cmd.vsort = 1'b1;
        cmd.sort_odd = cnt[0];
        if (cnt == SCW'(ED - 1)) begin
          cnt_next = '0;
          state_next = S_PREP;
        end else begin
          cnt_next = cnt + SCW'(1);
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = EM_EMPTY;
          state_next = S_IDLE;
        end
      end
      S_UPD: begin
        if (sts.head_ok) begin
          cmd.pop = 1'b1;
          state_next = S_RDP;
        end else begin
          cnt_next = '0;
          state_next = S_ESORT;
        end
      end
      S_RDP: begin
        cmd.rd_kind = RD_PREV;
        state_next = S_RDN;
      end
      S_RDN: begin
        cmd.rd_kind = RD_NEXT;
        cmd.lat_prev = 1'b1;
        state_next = S_RDC;
      end
      S_RDC: begin
        cmd.rd_kind = RD_CUR;
        cmd.lat_next = 1'b1;
        state_next = S_LATC;
      end
      S_LATC: begin
        cmd.lat_cur = 1'b1;
        state_next = S_DECP;
      end
      S_DECP: begin
        if (sts.prev_code == EC_REMOVE) begin
          cmd.remove = 1'b1;
          state_next = S_DECN;
        end else if (sts.prev_code == EC_ADD) begin
          cmd.add_setup = 1'b1;
          add_next_next = 1'b0;
          state_next = S_ADDCHK;
        end else begin
          state_next = S_DECN;
        end
      end
      S_DECN: begin
        cmd.sel_next = 1'b1;
        if (sts.next_code == EC_REMOVE) begin
          cmd.remove = 1'b1;
          state_next = S_UPD;
        end else if (sts.next_code == EC_ADD) begin
          cmd.add_setup = 1'b1;
          add_next_next = 1'b1;
          state_next = S_ADDCHK;
        end else begin
          state_next = S_UPD;
        end
      end
      S_ADDCHK: begin
        if (sts.add_ok) begin
          cmd.div_start = 1'b1;
          state_next = S_SDIV;
        end else begin
          state_next = add_next ? S_UPD : S_DECN;
        end
      end
      S_SDIV: begin
        if (sts.div_done) begin
          cmd.slope_store = 1'b1;
          cmd.mul = 1'b1;
          state_next = S_XSTART;
        end
      end
      S_XSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_x = 1'b1;
        state_next = S_XDIV;
      end
      S_XDIV: begin
        if (sts.div_done) begin
          cmd.edge_write = 1'b1;
          state_next = add_next ? S_UPD : S_DECN;
        end
      end
      S_ESORT: begin
        cmd.esort = 1'b1;
        cmd.sort_odd = cnt[0];
        if (cnt == SCW'(ED - 1)) begin
          cnt_next = '0;
          cmd.span_init = 1'b1;
          state_next = S_ROT;
        end else begin
          cnt_next = cnt + SCW'(1);
        end
      end
      S_ROT: begin
        if (!(sts.span_hit && sts.pend_valid && !sts.out_free)) begin
          cmd.rot = 1'b1;
          if (cnt == SCW'(ED / 2 - 1)) begin
            cnt_next = '0;
            state_next = S_FIN;
          end else begin
            cnt_next = cnt + SCW'(1);
          end
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.emit = EM_FINAL;
          cmd.row_update = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      add_next <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      add_next <= add_next_next;
    end
  end

endmodule

// ===== hw/rtl/concave_polygon_scan_converter_core.sv =====
// Even-odd polygon scan converter top level; depends on scp_pkg, scp_ctrl, scp_datapath.
// A vertex load is taken, stored and answered with a registered result; a final
// vertex adds one sort pass per vertex slot (MAX_VERTICES rounded up to even) and a prepare step.
// An advance reads the vertices crossed, inserts edges through the bit-serial divider,
// sorts and pairs the edges into spans, may stall on output; one item is worked at a time.
// Reset (rst, synchronous) empties the polygon; vertex and edge storage is not cleared.
module concave_polygon_scan_converter_core import scp_pkg::*; #(
  parameter int MAX_VERTICES = 32,
  parameter int COORD_FRAC_BITS = 4,
  parameter int EDGE_FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // vertex_x, vertex_y
  input  logic             s_axis_tuser,   // operation
  input  logic             s_axis_tlast,   // final_vertex
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // span_row, span_left, span_right, span_valid,
                                           // polygon_done, vertex_overflow, zero pad
  output logic             m_axis_tlast    // line_end
);

  cmd_t cmd;
  sts_t sts;

  scp_ctrl #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  scp_datapath #(
    .MAX_VERTICES    (MAX_VERTICES),
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .EDGE_FRAC_BITS  (EDGE_FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_axis_tdata),
    .s_tuser  (s_axis_tuser),
    .s_tlast  (s_axis_tlast),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata),
    .m_tlast  (m_axis_tlast)
  );

endmodule
